/* rtl/core/tga_rle_pkg.sv */
package tga_rle_pkg;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_IMAGE_KIND      = 2'd0,
    CFG_BYTES_PER_PIXEL = 2'd1,
    CFG_ALPHA_ENABLE    = 2'd2,
    CFG_PIXEL_COUNT     = 2'd3
  } cfg_index_t;

  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [1:0]  IMAGE_KIND_RESET      = 2'd0;
  localparam logic [2:0]  BYTES_PER_PIXEL_RESET = 3'd4;
  localparam logic        ALPHA_ENABLE_RESET    = 1'b0;
  localparam logic [31:0] PIXEL_COUNT_RESET     = 32'd1;

  localparam logic [7:0]  OPAQUE_ALPHA = 8'd255;
  localparam int unsigned RUN_FLAG_BIT = 7;

  typedef struct packed {
    logic [1:0]  image_kind;
    logic [2:0]  bytes_per_pixel;
    logic        alpha_enable;
    logic [31:0] pixel_count;
  } cfg_t;

  // One decoded pixel as handed from the front end to the back end.
  typedef struct packed {
    logic [31:0] pixel_bytes;
    logic [7:0]  repeat_count;
    logic        frame_done;
    logic        overrun;
  } pixel_rec_t;

  // Bytes per pixel as actually used: gray 1..2, color 2..4.
  function automatic logic [2:0] eff_bpp(input logic [2:0] bpp, input logic gray);
    logic [2:0] b;
    b = bpp;
    if (gray) begin
      if (b < 3'd1) b = 3'd1;
      if (b > 3'd2) b = 3'd2;
    end else begin
      if (b < 3'd2) b = 3'd2;
      if (b > 3'd4) b = 3'd4;
    end
    return b;
  endfunction

  // BGR(A) to RGB(A), ARGB1555 to RGBA5551, gray to luminance plus alpha.
  function automatic logic [31:0] convert_pixel(input logic [31:0] p, input cfg_t cfg);
    logic       gray;
    logic [2:0] bpp;
    logic [7:0] alpha;
    logic [31:0] res;
    gray = cfg.image_kind[1];
    bpp  = eff_bpp(cfg.bytes_per_pixel, gray);
    if (gray) begin
      alpha = (cfg.alpha_enable && bpp == 3'd2) ? p[15:8] : OPAQUE_ALPHA;
      res   = {16'd0, alpha, p[7:0]};
    end else if (bpp == 3'd2) begin
      res = {16'd0, p[14:0], (cfg.alpha_enable ? p[15] : 1'b1)};
    end else if (bpp == 3'd3) begin
      res = {8'd0, p[7:0], p[15:8], p[23:16]};
    end else begin
      alpha = cfg.alpha_enable ? p[31:24] : OPAQUE_ALPHA;
      res   = {alpha, p[7:0], p[15:8], p[23:16]};
    end
    return res;
  endfunction

endpackage

/* rtl/core/tga_rle_front.sv */
module tga_rle_front (
  input  logic                    clk,
  input  logic                    rst,
  input  tga_rle_pkg::cfg_t       cfg,
  input  logic                    restart,
  input  logic [31:0]             restart_count,
  input  logic                    accept,
  input  logic [7:0]              data_byte,
  output logic                    rec_valid,
  output tga_rle_pkg::pixel_rec_t rec
);

  logic        expect_hdr, expect_hdr_next;
  logic        run_packet, run_packet_next;
  logic [7:0]  pkt_left, pkt_left_next;
  logic [1:0]  byte_pos, byte_pos_next;
  logic [31:0] pixel_bytes, pixel_bytes_next;
  logic [31:0] frame_left, frame_left_next;

  logic        gray;
  logic        rle;
  logic [2:0]  bpp;
  logic [31:0] assembled;
  logic [31:0] left;
  logic [7:0]  want;
  logic [7:0]  rep;
  logic        clip;
  logic        over;
  logic        done;
  logic [31:0] left_after;

  assign gray = cfg.image_kind[1];
  assign rle  = cfg.image_kind[0];
  assign bpp  = tga_rle_pkg::eff_bpp(cfg.bytes_per_pixel, gray);

  always_comb begin
    expect_hdr_next  = expect_hdr;
    run_packet_next  = run_packet;
    pkt_left_next    = pkt_left;
    byte_pos_next    = byte_pos;
    pixel_bytes_next = pixel_bytes;
    frame_left_next  = frame_left;
    rec_valid        = 1'b0;

    assembled = (byte_pos == 2'd0) ? 32'd0 : pixel_bytes;
    case (byte_pos)
      2'd0:    assembled[7:0]   = data_byte;
      2'd1:    assembled[15:8]  = data_byte;
      2'd2:    assembled[23:16] = data_byte;
      default: assembled[31:24] = data_byte;
    endcase

    left       = (frame_left == 32'd0) ? 32'd1 : frame_left;
    want       = (rle && run_packet) ? pkt_left : 8'd1;
    if (want == 8'd0) want = 8'd1;
    clip       = left < {24'd0, want};
    rep        = clip ? left[7:0] : want;
    left_after = left - {24'd0, rep};
    done       = (left_after == 32'd0);
    over       = clip;

    if (accept) begin
      if (rle && expect_hdr) begin
        run_packet_next = data_byte[tga_rle_pkg::RUN_FLAG_BIT];
        pkt_left_next   = {1'b0, data_byte[6:0]} + 8'd1;
        expect_hdr_next = 1'b0;
        byte_pos_next   = 2'd0;
      end else if (({1'b0, byte_pos} + 3'd1) < bpp) begin
        byte_pos_next    = byte_pos + 2'd1;
        pixel_bytes_next = assembled;
      end else begin
        rec_valid        = 1'b1;
        byte_pos_next    = 2'd0;
        pixel_bytes_next = assembled;
        frame_left_next  = left_after;
        if (rle) begin
          if (run_packet) begin
            pkt_left_next = 8'd0;
          end else if (pkt_left != 8'd0) begin
            pkt_left_next = pkt_left - 8'd1;
          end
          if (pkt_left_next == 8'd0) begin
            expect_hdr_next = 1'b1;
          end else if (done) begin
            // Raw packet cut short by the end of the frame.
            over = 1'b1;
          end
        end
        if (done) begin
          expect_hdr_next  = 1'b1;
          run_packet_next  = 1'b0;
          pkt_left_next    = 8'd0;
          byte_pos_next    = 2'd0;
          pixel_bytes_next = 32'd0;
          frame_left_next  = cfg.pixel_count;
        end
      end
    end
  end

  assign rec.pixel_bytes  = assembled;
  assign rec.repeat_count = rep;
  assign rec.frame_done   = done;
  assign rec.overrun      = over;

  always_ff @(posedge clk) begin
    if (rst) begin
      expect_hdr  <= 1'b1;
      run_packet  <= 1'b0;
      pkt_left    <= 8'd0;
      byte_pos    <= 2'd0;
      pixel_bytes <= 32'd0;
      frame_left  <= tga_rle_pkg::PIXEL_COUNT_RESET;
    end else if (restart) begin
      expect_hdr  <= 1'b1;
      run_packet  <= 1'b0;
      pkt_left    <= 8'd0;
      byte_pos    <= 2'd0;
      pixel_bytes <= 32'd0;
      frame_left  <= restart_count;
    end else begin
      expect_hdr  <= expect_hdr_next;
      run_packet  <= run_packet_next;
      pkt_left    <= pkt_left_next;
      byte_pos    <= byte_pos_next;
      pixel_bytes <= pixel_bytes_next;
      frame_left  <= frame_left_next;
    end
  end

endmodule

/* rtl/core/tga_rle_queue.sv */
module tga_rle_queue #(
  parameter int unsigned DEPTH = tga_rle_pkg::QUEUE_DEPTH
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    wr_en,
  input  tga_rle_pkg::pixel_rec_t wr_data,
  input  logic                    rd_en,
  output tga_rle_pkg::pixel_rec_t rd_data,
  output logic                    q_full,
  output logic                    q_empty
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);

  tga_rle_pkg::pixel_rec_t mem [DEPTH];

  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign q_full  = (count == CntW'(DEPTH));
  assign q_empty = (count == '0);
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      end
      case ({wr_en, rd_en})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* rtl/core/tga_rle_back.sv */
module tga_rle_back (
  input  logic                    clk,
  input  logic                    rst,
  input  tga_rle_pkg::cfg_t       cfg,
  input  logic                    q_empty,
  input  tga_rle_pkg::pixel_rec_t q_data,
  output logic                    q_pop,
  input  logic                    pop,
  output logic                    empty,
  output logic [31:0]             pixel_value,
  output logic [7:0]              repeat_count,
  output logic                    frame_done,
  output logic                    overrun
);

  logic out_valid;

  assign q_pop = !q_empty && (!out_valid || pop);
  assign empty = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      pixel_value  <= tga_rle_pkg::convert_pixel(q_data.pixel_bytes, cfg);
      repeat_count <= q_data.repeat_count;
      frame_done   <= q_data.frame_done;
      overrun      <= q_data.overrun;
    end
  end

endmodule

/* rtl/core/tga_rle_pixel_decoder_unit.sv */
// TGA run-length pixel decoder. Software parses the TGA header and writes
// image_kind, bytes_per_pixel, alpha_enable and pixel_count; the block then
// takes the pixel-data bytes one per cycle through push/full and returns one
// converted pixel per result transaction through empty/pop. A run packet
// yields a single result whose repeat_count is the run length, raw pixels
// yield one result each with repeat_count 1, and packet header bytes yield no
// result. Counts that pass the end of the frame are clipped and flagged with
// overrun; the result that completes the frame carries frame_done and the next
// byte starts a new frame. Any configuration write restarts the frame, and
// configuration must only be written while no results are outstanding.
// Throughput is one byte per cycle while full is low and up to one result per
// cycle: the front end does all packet and frame bookkeeping for a byte in the
// cycle it is taken, a small queue (QueueDepth entries) decouples it from the
// back end, and the back end converts the pixel into an output register. A
// pixel's record is registered in the queue, then in the output register.
module tga_rle_pixel_decoder_unit #(
  parameter int unsigned QueueDepth = tga_rle_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  // Byte input, queue style.
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte,
  // Result output, queue style.
  output logic        empty,
  input  logic        pop,
  output logic [31:0] pixel_value,
  output logic [7:0]  repeat_count,
  output logic        frame_done,
  output logic        overrun,
  // Configuration write channel.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  tga_rle_pkg::cfg_t       cfg;
  tga_rle_pkg::pixel_rec_t front_rec;
  tga_rle_pkg::pixel_rec_t q_data;

  logic        cfg_write;
  logic [31:0] restart_count;
  logic        accept;
  logic        rec_valid;
  logic        q_full;
  logic        q_empty;
  logic        q_pop;

  // Registers are always writable; a write is a single transaction.
  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  // The frame restarts with the pixel count that is in force after the write.
  assign restart_count = (cfg_index == tga_rle_pkg::CFG_PIXEL_COUNT) ? cfg_data
                                                                       : cfg.pixel_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.image_kind      <= tga_rle_pkg::IMAGE_KIND_RESET;
      cfg.bytes_per_pixel <= tga_rle_pkg::BYTES_PER_PIXEL_RESET;
      cfg.alpha_enable    <= tga_rle_pkg::ALPHA_ENABLE_RESET;
      cfg.pixel_count     <= tga_rle_pkg::PIXEL_COUNT_RESET;
    end else if (cfg_write) begin
      unique case (tga_rle_pkg::cfg_index_t'(cfg_index))
        tga_rle_pkg::CFG_IMAGE_KIND:      cfg.image_kind      <= cfg_data[1:0];
        tga_rle_pkg::CFG_BYTES_PER_PIXEL: cfg.bytes_per_pixel <= cfg_data[2:0];
        tga_rle_pkg::CFG_ALPHA_ENABLE:    cfg.alpha_enable    <= cfg_data[0];
        tga_rle_pkg::CFG_PIXEL_COUNT:     cfg.pixel_count     <= cfg_data;
        default:                          cfg.pixel_count     <= cfg.pixel_count;
      endcase
    end
  end

  // A byte is taken whenever the queue has room for the pixel it may finish.
  assign full   = q_full;
  assign accept = push && !full;

  tga_rle_front u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .restart       (cfg_write),
    .restart_count (restart_count),
    .accept        (accept),
    .data_byte     (data_byte),
    .rec_valid     (rec_valid),
    .rec           (front_rec)
  );

  tga_rle_queue #(
    .DEPTH (QueueDepth)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (rec_valid),
    .wr_data (front_rec),
    .rd_en   (q_pop),
    .rd_data (q_data),
    .q_full  (q_full),
    .q_empty (q_empty)
  );

  tga_rle_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .q_empty      (q_empty),
    .q_data       (q_data),
    .q_pop        (q_pop),
    .pop          (pop),
    .empty        (empty),
    .pixel_value  (pixel_value),
    .repeat_count (repeat_count),
    .frame_done   (frame_done),
    .overrun      (overrun)
  );

`ifndef ASSERT_OFF
  // Every result stands for at least one pixel and at most one full packet.
  a_rep_nonzero: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (repeat_count != 8'd0 && repeat_count <= 8'd128))
    else $error("repeat_count out of range");

  // A clipped count can only happen on the pixel that ends the frame.
  a_over_done: assert property (@(posedge clk) disable iff (rst)
    (!empty && overrun) |-> frame_done)
    else $error("overrun without frame_done");

  // Raw kinds have no packets, so nothing can be clipped.
  a_raw_no_over: assert property (@(posedge clk) disable iff (rst)
    (!empty && !cfg.image_kind[0]) |-> !overrun)
    else $error("overrun in a raw image kind");

  // A result left waiting must hold until it is popped.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(pixel_value) && $stable(repeat_count)))
    else $error("waiting result changed");
`endif

endmodule
